>>> sv/u8bsd_pkg.sv
package u8bsd_pkg;

	localparam int CP_W      = 21;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 3;
	localparam int LEFT_W    = 2;
	localparam int CFG_IDX_W = 1;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE_POINT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBSTITUTE_CODE = 1'd1;

	// config reset values
	localparam logic [CP_W-1:0] MAX_CODE_POINT_RST  = 21'd512;
	localparam logic [CP_W-1:0] SUBSTITUTE_CODE_RST = 21'd32;

	// lead byte class bounds
	localparam logic [BYTE_W-1:0] LEAD1_MAX = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;

	// payload masks
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
	localparam int                CONT_BITS  = 6;

	// sequence lengths
	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

	typedef logic [CP_W-1:0]   cp_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [LEFT_W-1:0] left_t;

endpackage

>>> sv/u8bsd_byte_if.sv
interface u8bsd_byte_if;
	logic                 valid;
	logic                 ready;
	u8bsd_pkg::byte_t     data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

>>> sv/u8bsd_cp_if.sv
interface u8bsd_cp_if;
	logic                 valid;
	logic                 ready;
	u8bsd_pkg::cp_t       code_point;
	u8bsd_pkg::len_t      seq_length;
	logic                 substituted;

	modport source (output valid, output code_point, output seq_length, output substituted,
		input ready);
	modport sink (input valid, input code_point, input seq_length, input substituted,
		output ready);
endinterface

>>> sv/utf8_byte_stream_decoder_core.sv
// channel   dir  payload                                  handshake
// byte_in   in   data_byte[7:0]                           valid/ready
// cp_out    out  code_point[20:0] seq_length[2:0] subst.  valid/ready
// cfg       in   cfg_index[0] cfg_data[20:0]              cfg_wr_en, no wait
//
// one byte per cycle while byte_in.ready is high; a code point appears in the cycle after its last byte
// is taken, from the result register
// the only loop is the accumulator/bytes-left/length register, updated each byte
// byte_in.ready is low only while a result waits and cp_out.ready is low
// arst_n clears the decode state and the result valid and reloads the
// config registers with their defaults
module utf8_byte_stream_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [u8bsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [u8bsd_pkg::CP_W-1:0]        cfg_data,
	u8bsd_byte_if.sink                        byte_in,
	u8bsd_cp_if.source                        cp_out
);

	u8bsd_pkg::cp_t   max_cp_q;
	u8bsd_pkg::cp_t   subst_q;
	u8bsd_pkg::cp_t   acc_q;
	u8bsd_pkg::left_t left_q;
	u8bsd_pkg::len_t  total_q;

	u8bsd_pkg::cp_t   acc_d;
	u8bsd_pkg::left_t left_d;
	u8bsd_pkg::len_t  total_d;
	logic             emit;
	u8bsd_pkg::cp_t   emit_val;
	u8bsd_pkg::len_t  emit_len;
	logic             over;

	logic             out_valid_q;
	u8bsd_pkg::cp_t   out_cp_q;
	u8bsd_pkg::len_t  out_len_q;
	logic             out_sub_q;

	logic             take;
	u8bsd_pkg::byte_t b;

	assign b    = byte_in.data_byte;
	assign take = byte_in.valid && byte_in.ready;
	assign byte_in.ready = !out_valid_q || cp_out.ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cp_q <= u8bsd_pkg::MAX_CODE_POINT_RST;
			subst_q  <= u8bsd_pkg::SUBSTITUTE_CODE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				u8bsd_pkg::REG_MAX_CODE_POINT:  max_cp_q <= cfg_data;
				u8bsd_pkg::REG_SUBSTITUTE_CODE: subst_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// next decode state and result for the incoming byte
	always_comb begin
		acc_d    = acc_q;
		left_d   = left_q;
		total_d  = total_q;
		emit     = 1'b0;
		emit_val = '0;
		emit_len = u8bsd_pkg::LEN_NONE;
		if (left_q == '0) begin
			if (b <= u8bsd_pkg::LEAD1_MAX) begin
				acc_d    = '0;
				total_d  = u8bsd_pkg::LEN_NONE;
				emit     = 1'b1;
				emit_val = u8bsd_pkg::cp_t'(b);
				emit_len = u8bsd_pkg::LEN_1;
			end else if (b <= u8bsd_pkg::LEAD2_MAX) begin
				acc_d   = u8bsd_pkg::cp_t'(b & u8bsd_pkg::LEAD2_MASK);
				total_d = u8bsd_pkg::LEN_2;
				left_d  = 2'd1;
			end else if (b <= u8bsd_pkg::LEAD3_MAX) begin
				acc_d   = u8bsd_pkg::cp_t'(b & u8bsd_pkg::LEAD3_MASK);
				total_d = u8bsd_pkg::LEN_3;
				left_d  = 2'd2;
			end else begin
				acc_d   = u8bsd_pkg::cp_t'(b & u8bsd_pkg::LEAD4_MASK);
				total_d = u8bsd_pkg::LEN_4;
				left_d  = 2'd3;
			end
		end else begin
			// continuation: shift in six payload bits, top bits unchecked
			left_d = left_q - 2'd1;
			if (left_q == 2'd1) begin
				emit     = 1'b1;
				emit_val = {acc_q[u8bsd_pkg::CP_W-u8bsd_pkg::CONT_BITS-1:0],
					b[u8bsd_pkg::CONT_BITS-1:0]};
				emit_len = total_q;
				acc_d    = '0;
				total_d  = u8bsd_pkg::LEN_NONE;
			end else begin
				acc_d = {acc_q[u8bsd_pkg::CP_W-u8bsd_pkg::CONT_BITS-1:0],
					b[u8bsd_pkg::CONT_BITS-1:0]};
			end
		end
	end

	assign over = emit_val > max_cp_q;

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			left_q  <= '0;
			total_q <= u8bsd_pkg::LEN_NONE;
		end else if (take) begin
			acc_q   <= acc_d;
			left_q  <= left_d;
			total_q <= total_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
		end else if (cp_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload with limit substitution
	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_cp_q  <= over ? subst_q : emit_val;
			out_len_q <= emit_len;
			out_sub_q <= over;
		end
	end

	assign cp_out.valid       = out_valid_q;
	assign cp_out.code_point  = out_cp_q;
	assign cp_out.seq_length  = out_len_q;
	assign cp_out.substituted = out_sub_q;

endmodule
